// File: src/npc_pkg.sv
`timescale 1ns / 1ps
// npc_pkg: shared types, constants and component access helpers
// for the near-plane triangle clipper; no dependencies

package npc_pkg;

    localparam int POS_FRAC_BITS = 16;
    localparam int T_BITS        = 16;
    localparam int NUM_COMPS     = 11;
    localparam int COMP_W        = 33;
    localparam int DIV_W         = 34;

    typedef logic [3:0] comp_idx_t;

    typedef struct packed {
        logic signed [31:0] in_pos_x;
        logic signed [31:0] in_pos_y;
        logic signed [31:0] in_pos_z;
        logic signed [31:0] in_pos_w;
        logic [15:0]        in_color_r;
        logic [15:0]        in_color_g;
        logic [15:0]        in_color_b;
        logic [15:0]        in_color_a;
        logic signed [15:0] in_normal_x;
        logic signed [15:0] in_normal_y;
        logic signed [15:0] in_normal_z;
    } vert_t;

    typedef struct packed {
        logic signed [31:0] out_pos_x;
        logic signed [31:0] out_pos_y;
        logic signed [31:0] out_pos_z;
        logic signed [31:0] out_pos_w;
        logic [15:0]        out_color_r;
        logic [15:0]        out_color_g;
        logic [15:0]        out_color_b;
        logic [15:0]        out_color_a;
        logic signed [15:0] out_normal_x;
        logic signed [15:0] out_normal_y;
        logic signed [15:0] out_normal_z;
        logic               last_vertex;
    } emit_t;

    // divider handshake toward the sequencer
    typedef struct packed {
        logic              done;
        logic [T_BITS-1:0] quot;
    } div_stat_t;

    // one component of a vertex, widened to a common signed width
    function automatic logic signed [COMP_W-1:0] comp_get(vert_t v, comp_idx_t idx);
        logic signed [COMP_W-1:0] r;
        r = '0;
        unique case (idx)
            4'd0:    r = {v.in_pos_x[31], v.in_pos_x};
            4'd1:    r = {v.in_pos_y[31], v.in_pos_y};
            4'd2:    r = {v.in_pos_z[31], v.in_pos_z};
            4'd3:    r = {v.in_pos_w[31], v.in_pos_w};
            4'd4:    r = {17'd0, v.in_color_r};
            4'd5:    r = {17'd0, v.in_color_g};
            4'd6:    r = {17'd0, v.in_color_b};
            4'd7:    r = {17'd0, v.in_color_a};
            4'd8:    r = {{17{v.in_normal_x[15]}}, v.in_normal_x};
            4'd9:    r = {{17{v.in_normal_y[15]}}, v.in_normal_y};
            4'd10:   r = {{17{v.in_normal_z[15]}}, v.in_normal_z};
            default: r = '0;
        endcase
        return r;
    endfunction

    // write one component back, truncated to its field width
    function automatic vert_t comp_set(vert_t v, comp_idx_t idx,
                                       logic signed [COMP_W-1:0] val);
        vert_t r;
        r = v;
        unique case (idx)
            4'd0:    r.in_pos_x    = val[31:0];
            4'd1:    r.in_pos_y    = val[31:0];
            4'd2:    r.in_pos_z    = val[31:0];
            4'd3:    r.in_pos_w    = val[31:0];
            4'd4:    r.in_color_r  = val[15:0];
            4'd5:    r.in_color_g  = val[15:0];
            4'd6:    r.in_color_b  = val[15:0];
            4'd7:    r.in_color_a  = val[15:0];
            4'd8:    r.in_normal_x = val[15:0];
            4'd9:    r.in_normal_y = val[15:0];
            4'd10:   r.in_normal_z = val[15:0];
            default: r = v;
        endcase
        return r;
    endfunction

endpackage

// File: src/near_plane_triangle_clipper.sv
`timescale 1ns / 1ps
// near_plane_triangle_clipper: the first two vertices of a triangle are only stored.
// Third vertex: a classify step, per edge a setup step plus, for a real
// crossing, a divide and then a multiply and an add per component on the shared
// interpolation multiplier, then a pick step and the emitted vertices one at a time,
// held while emit_ready is low; at most two sides cross. Not ready until the triangle
// is done. Reset clears the phase and sequencer. Depends on npc_pkg and npc_div.

module near_plane_triangle_clipper (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            vert_valid,
    output logic            vert_ready,
    input  npc_pkg::vert_t  vert,
    output logic            emit_valid,
    input  logic            emit_ready,
    output npc_pkg::emit_t  emit
);
    import npc_pkg::*;

    typedef enum logic [2:0] {
        ST_IDLE, ST_CLASS, ST_EDGE, ST_DIV, ST_MUL, ST_ADD, ST_PICK, ST_EMIT
    } state_t;

    typedef enum logic [2:0] {
        SEL_V0, SEL_V1, SEL_V2, SEL_C0, SEL_C1, SEL_C2
    } sel_t;

    localparam logic signed [DIV_W-1:0] ONE_W = DIV_W'(1) <<< POS_FRAC_BITS;

    state_t            state_reg;
    logic [1:0]        phase_reg;
    logic [1:0]        edge_reg;
    comp_idx_t         comp_reg;
    logic [2:0]        inside_reg;
    logic [2:0]        cross_ok_reg;
    logic [2:0]        cnt_reg;
    logic [2:0]        k_reg;
    sel_t              sel_reg [6];
    logic              out_valid_reg;
    emit_t             out_reg;

    vert_t             v_reg [3];
    vert_t             c_reg [3];
    logic [T_BITS-1:0] t_reg;
    logic signed [COMP_W+T_BITS+1:0] prod_reg;

    // edge endpoints
    vert_t                    va, vb;
    logic signed [DIV_W-1:0]  wa, wb, num, den;
    logic [DIV_W-1:0]         an, ad;
    logic                     edge_ok;
    logic                     div_start;
    div_stat_t                div_stat;

    always_comb
    begin
        unique case (edge_reg)
            2'd0:    begin va = v_reg[0]; vb = v_reg[1]; end
            2'd1:    begin va = v_reg[1]; vb = v_reg[2]; end
            default: begin va = v_reg[2]; vb = v_reg[0]; end
        endcase
    end

    // crossing test on w = 1
    assign wa      = DIV_W'(va.in_pos_w);
    assign wb      = DIV_W'(vb.in_pos_w);
    assign num     = ONE_W - wa;
    assign den     = wb - wa;
    assign an      = num[DIV_W-1] ? -num : num;
    assign ad      = den[DIV_W-1] ? -den : den;
    assign edge_ok = (num != '0) && (den != '0) && (num[DIV_W-1] == den[DIV_W-1])
                     && (an < ad);
    assign div_start = (state_reg == ST_EDGE) && edge_ok;

    npc_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .start (div_start),
        .num   (an),
        .den   (ad),
        .stat  (div_stat)
    );

    // shared interpolation unit operands
    logic signed [COMP_W-1:0]          ca, cb;
    logic signed [COMP_W:0]            diff;
    logic signed [COMP_W+T_BITS+1:0]   prod;
    logic signed [COMP_W+2:0]          lerp_sum;

    assign ca       = comp_get(va, comp_reg);
    assign cb       = comp_get(vb, comp_reg);
    assign diff     = {cb[COMP_W-1], cb} - {ca[COMP_W-1], ca};
    assign prod     = diff * $signed({1'b0, t_reg});
    assign lerp_sum = (COMP_W+3)'(ca) + (COMP_W+3)'(prod_reg >>> T_BITS);

    // vertex by selector code
    function automatic vert_t pick_vert(sel_t s, vert_t v0, vert_t v1, vert_t v2,
                                        vert_t c0, vert_t c1, vert_t c2);
        vert_t r;
        r = v0;
        unique case (s)
            SEL_V0:  r = v0;
            SEL_V1:  r = v1;
            SEL_V2:  r = v2;
            SEL_C0:  r = c0;
            SEL_C1:  r = c1;
            SEL_C2:  r = c2;
            default: r = v0;
        endcase
        return r;
    endfunction

    vert_t emit_v;
    assign emit_v = pick_vert(sel_reg[k_reg], v_reg[0], v_reg[1], v_reg[2],
                              c_reg[0], c_reg[1], c_reg[2]);

    // sequencer and output register control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            phase_reg     <= '0;
            edge_reg      <= '0;
            comp_reg      <= '0;
            inside_reg    <= '0;
            cross_ok_reg  <= '0;
            cnt_reg       <= '0;
            k_reg         <= '0;
            out_valid_reg <= 1'b0;
            for (int i = 0; i < 6; i++)
            begin
                sel_reg[i] <= SEL_V0;
            end
        end
        else
        begin
            if (out_valid_reg && emit_ready)
            begin
                out_valid_reg <= 1'b0;
            end
            unique case (state_reg)
                ST_IDLE:
                begin
                    if (vert_valid)
                    begin
                        if (phase_reg == 2'd0 || phase_reg == 2'd1)
                        begin
                            phase_reg <= phase_reg + 2'd1;
                        end
                        else
                        begin
                            phase_reg <= '0;
                            state_reg <= ST_CLASS;
                        end
                    end
                end
                ST_CLASS:
                begin
                    inside_reg[0] <= v_reg[0].in_pos_w > 32'(ONE_W);
                    inside_reg[1] <= v_reg[1].in_pos_w > 32'(ONE_W);
                    inside_reg[2] <= v_reg[2].in_pos_w > 32'(ONE_W);
                    edge_reg      <= '0;
                    cross_ok_reg  <= '0;
                    state_reg     <= ST_PICK;
                    if ((v_reg[0].in_pos_w > 32'(ONE_W)) || (v_reg[1].in_pos_w > 32'(ONE_W))
                        || (v_reg[2].in_pos_w > 32'(ONE_W)))
                    begin
                        if (!((v_reg[0].in_pos_w > 32'(ONE_W))
                              && (v_reg[1].in_pos_w > 32'(ONE_W))
                              && (v_reg[2].in_pos_w > 32'(ONE_W))))
                        begin
                            state_reg <= ST_EDGE;
                        end
                    end
                end
                ST_EDGE:
                begin
                    cross_ok_reg[edge_reg] <= edge_ok;
                    if (edge_ok)
                    begin
                        state_reg <= ST_DIV;
                    end
                    else if (edge_reg == 2'd2)
                    begin
                        state_reg <= ST_PICK;
                    end
                    else
                    begin
                        edge_reg <= edge_reg + 2'd1;
                    end
                end
                ST_DIV:
                begin
                    if (div_stat.done)
                    begin
                        comp_reg  <= '0;
                        state_reg <= ST_MUL;
                    end
                end
                ST_MUL:
                begin
                    state_reg <= ST_ADD;
                end
                ST_ADD:
                begin
                    if (comp_reg == 4'(NUM_COMPS - 1))
                    begin
                        if (edge_reg == 2'd2)
                        begin
                            state_reg <= ST_PICK;
                        end
                        else
                        begin
                            edge_reg  <= edge_reg + 2'd1;
                            state_reg <= ST_EDGE;
                        end
                    end
                    else
                    begin
                        comp_reg  <= comp_reg + 4'd1;
                        state_reg <= ST_MUL;
                    end
                end
                ST_PICK:
                begin
                    k_reg     <= '0;
                    cnt_reg   <= '0;
                    state_reg <= ST_IDLE;
                    if (inside_reg == 3'b111)
                    begin
                        sel_reg[0] <= SEL_V0; sel_reg[1] <= SEL_V1; sel_reg[2] <= SEL_V2;
                        cnt_reg <= 3'd3; state_reg <= ST_EMIT;
                    end
                    else if (cross_ok_reg[0] && cross_ok_reg[1])
                    begin
                        state_reg <= ST_EMIT;
                        if (inside_reg[1])
                        begin
                            sel_reg[0] <= SEL_C0; sel_reg[1] <= SEL_V1; sel_reg[2] <= SEL_C1;
                            cnt_reg <= 3'd3;
                        end
                        else
                        begin
                            sel_reg[0] <= SEL_V0; sel_reg[1] <= SEL_C0; sel_reg[2] <= SEL_V2;
                            sel_reg[3] <= SEL_V2; sel_reg[4] <= SEL_C0; sel_reg[5] <= SEL_C1;
                            cnt_reg <= 3'd6;
                        end
                    end
                    else if (cross_ok_reg[1] && cross_ok_reg[2])
                    begin
                        state_reg <= ST_EMIT;
                        if (inside_reg[2])
                        begin
                            sel_reg[0] <= SEL_C2; sel_reg[1] <= SEL_C1; sel_reg[2] <= SEL_V2;
                            cnt_reg <= 3'd3;
                        end
                        else
                        begin
                            sel_reg[0] <= SEL_V0; sel_reg[1] <= SEL_V1; sel_reg[2] <= SEL_C1;
                            sel_reg[3] <= SEL_V0; sel_reg[4] <= SEL_C1; sel_reg[5] <= SEL_C2;
                            cnt_reg <= 3'd6;
                        end
                    end
                    else if (cross_ok_reg[0] && cross_ok_reg[2])
                    begin
                        state_reg <= ST_EMIT;
                        if (inside_reg[0])
                        begin
                            sel_reg[0] <= SEL_V0; sel_reg[1] <= SEL_C0; sel_reg[2] <= SEL_C2;
                            cnt_reg <= 3'd3;
                        end
                        else
                        begin
                            sel_reg[0] <= SEL_C0; sel_reg[1] <= SEL_V1; sel_reg[2] <= SEL_V2;
                            sel_reg[3] <= SEL_V2; sel_reg[4] <= SEL_C2; sel_reg[5] <= SEL_C0;
                            cnt_reg <= 3'd6;
                        end
                    end
                end
                ST_EMIT:
                begin
                    if (!out_valid_reg || emit_ready)
                    begin
                        out_valid_reg <= 1'b1;
                        k_reg         <= k_reg + 3'd1;
                        if (k_reg == cnt_reg - 3'd1)
                        begin
                            state_reg <= ST_IDLE;
                        end
                    end
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (state_reg == ST_IDLE && vert_valid)
        begin
            if (phase_reg == 2'd0)
            begin
                v_reg[0] <= vert;
            end
            else if (phase_reg == 2'd1)
            begin
                v_reg[1] <= vert;
            end
            else
            begin
                v_reg[2] <= vert;
            end
        end
        if (state_reg == ST_DIV && div_stat.done)
        begin
            t_reg <= div_stat.quot;
        end
        if (state_reg == ST_MUL)
        begin
            prod_reg <= prod;
        end
        if (state_reg == ST_ADD)
        begin
            c_reg[edge_reg] <= comp_set(c_reg[edge_reg], comp_reg,
                                        lerp_sum[COMP_W-1:0]);
        end
        if (state_reg == ST_EMIT && (!out_valid_reg || emit_ready))
        begin
            out_reg.out_pos_x    <= emit_v.in_pos_x;
            out_reg.out_pos_y    <= emit_v.in_pos_y;
            out_reg.out_pos_z    <= emit_v.in_pos_z;
            out_reg.out_pos_w    <= emit_v.in_pos_w;
            out_reg.out_color_r  <= emit_v.in_color_r;
            out_reg.out_color_g  <= emit_v.in_color_g;
            out_reg.out_color_b  <= emit_v.in_color_b;
            out_reg.out_color_a  <= emit_v.in_color_a;
            out_reg.out_normal_x <= emit_v.in_normal_x;
            out_reg.out_normal_y <= emit_v.in_normal_y;
            out_reg.out_normal_z <= emit_v.in_normal_z;
            out_reg.last_vertex  <= (k_reg == cnt_reg - 3'd1);
        end
    end

    assign vert_ready = (state_reg == ST_IDLE);
    assign emit_valid = out_valid_reg;
    assign emit       = out_reg;

endmodule

// File: src/npc_div.sv
`timescale 1ns / 1ps
// npc_div: restoring divider giving floor(num * 2^16 / den) for num < den,
// one quotient bit per cycle; depends on npc_pkg

module npc_div (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       start,
    input  logic [npc_pkg::DIV_W-1:0]  num,
    input  logic [npc_pkg::DIV_W-1:0]  den,
    output npc_pkg::div_stat_t         stat
);
    import npc_pkg::*;

    logic              busy_reg;
    logic              done_reg;
    logic [4:0]        cnt_reg;
    logic [DIV_W-1:0]  rem_reg;
    logic [DIV_W-1:0]  den_reg;
    logic [T_BITS-1:0] quot_reg;

    logic [DIV_W:0]    rem_dbl;
    logic              fits;

    // shift and trial subtract
    assign rem_dbl = {rem_reg, 1'b0};
    assign fits    = rem_dbl >= {1'b0, den_reg};

    // control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg + 5'd1;
                if (cnt_reg == 5'(T_BITS - 1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    // datapath, the remainder stays below den when num < den
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            rem_reg  <= num;
            den_reg  <= den;
            quot_reg <= '0;
        end
        else if (busy_reg)
        begin
            rem_reg  <= fits ? DIV_W'(rem_dbl - {1'b0, den_reg}) : rem_dbl[DIV_W-1:0];
            quot_reg <= {quot_reg[T_BITS-2:0], fits};
        end
    end

    assign stat.done = done_reg;
    assign stat.quot = quot_reg;

endmodule
